FILE: sv/cgp_pkg.sv
// Package for the color grading pixel block: widths, register codes, lane config struct.
package cgp_pkg;

    localparam int FRAC_BITS_DEF = 12;
    localparam int PIX_W         = 13;
    localparam int OUT_W         = 8;
    localparam int REG_W         = 48;
    localparam int LANE_W        = 16;
    localparam int NUM_CHAN      = 3;
    localparam int CFG_IDX_W     = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SHADOW    = 4'd0,
        REG_MIDTONE   = 4'd1,
        REG_HIGHLIGHT = 4'd2,
        REG_BLACK     = 4'd3,
        REG_MULTIPLY  = 4'd4,
        REG_SCREEN    = 4'd5,
        REG_DODGE     = 4'd6,
        REG_BURN      = 4'd7
    } reg_idx_t;

    // Per-channel settings, signed Q3.FRAC_BITS
    typedef struct packed {
        logic signed [LANE_W-1:0] shadow;
        logic signed [LANE_W-1:0] midtone;
        logic signed [LANE_W-1:0] highlight;
        logic signed [LANE_W-1:0] black;
        logic signed [LANE_W-1:0] mult;
        logic signed [LANE_W-1:0] screen;
        logic signed [LANE_W-1:0] dodge;
        logic signed [LANE_W-1:0] burn;
    } chan_cfg_t;

    // Lane pipeline depth: 19 arithmetic stages plus two dividers of 2F+1 steps
    function automatic int lane_latency(input int f);
        return 19 + 2 * (2 * f + 1);
    endfunction

endpackage

FILE: sv/cgp_div.sv
// Pipelined restoring divider, one quotient bit per stage, with a tag carried alongside.
module cgp_div #(
    parameter int NW = 25,
    parameter int DW = 13,
    parameter int TG = 13
) (
    input  logic          clk,
    input  logic          en,
    input  logic [NW-1:0] num_in,
    input  logic [DW-1:0] den_in,
    input  logic [TG-1:0] tag_in,
    output logic [NW-1:0] quo_out,
    output logic [TG-1:0] tag_out
);

    logic [DW-1:0] rem_reg [NW-1];
    logic [DW-1:0] den_reg [NW-1];
    logic [NW-1:0] num_reg [NW];
    logic [TG-1:0] tag_reg [NW];

    for (genvar k = 0; k < NW; k++) begin : g_step
        logic [DW-1:0] rem_i;
        logic [DW-1:0] den_i;
        logic [NW-1:0] num_i;
        logic [TG-1:0] tag_i;
        logic [DW:0]   cand;
        logic          ge;

        if (k == 0) begin : g_first
            assign rem_i = '0;
            assign den_i = den_in;
            assign num_i = num_in;
            assign tag_i = tag_in;
        end
        else begin : g_next
            assign rem_i = rem_reg[k-1];
            assign den_i = den_reg[k-1];
            assign num_i = num_reg[k-1];
            assign tag_i = tag_reg[k-1];
        end

        assign cand = {rem_i, num_i[NW-1]};
        assign ge   = (cand >= {1'b0, den_i});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                num_reg[k] <= {num_i[NW-2:0], ge};
                tag_reg[k] <= tag_i;
            end
        end

        if (k < NW - 1) begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= ge ? DW'(cand - {1'b0, den_i}) : cand[DW-1:0];
                    den_reg[k] <= den_i;
                end
            end
        end
    end

    assign quo_out = num_reg[NW-1];
    assign tag_out = tag_reg[NW-1];

endmodule

FILE: sv/cgp_lane.sv
// One channel of the grading pipeline: tone curve, black level, blends, 8-bit rounding.
module cgp_lane #(
    parameter int FRAC_BITS = cgp_pkg::FRAC_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      en,
    input  logic [cgp_pkg::PIX_W-1:0] x_in,
    input  cgp_pkg::chan_cfg_t        cfg,
    output logic [cgp_pkg::OUT_W-1:0] pix_out
);

    localparam int F   = FRAC_BITS;
    localparam int VW  = F + 1;
    localparam int CW  = 3 * F + 24;
    localparam int NW  = 2 * F + 1;
    localparam int LW  = cgp_pkg::LANE_W;
    localparam int PW1 = LW + VW + 1;
    localparam int TW  = ((2 * F + 2 > F + 17) ? 2 * F + 2 : F + 17) + 1;
    localparam int PW7 = VW + 1 + TW;
    localparam int MINDIV = ((1 << F) + 127) / 255;

    localparam logic [VW-1:0]        ONE_V = {1'b1, {F{1'b0}}};
    localparam logic [VW-1:0]        MIN_V = VW'(MINDIV);
    localparam logic signed [CW-1:0] ONE_C = {{(CW-F-1){1'b0}}, 1'b1, {F{1'b0}}};

    function automatic logic [VW-1:0] clamp1(input logic signed [CW-1:0] a);
        if (a < 0)
            return '0;
        else if (a > ONE_C)
            return ONE_V;
        else
            return a[VW-1:0];
    endfunction

    // round to nearest, halves up: floor((a + 2^(s-1)) / 2^s)
    function automatic logic signed [CW-1:0] rnd(input logic signed [CW-1:0] a, input int s);
        logic signed [CW-1:0] half;
        half = CW'(1) <<< (s - 1);
        return (a + half) >>> s;
    endfunction

    function automatic logic signed [CW-1:0] ext(input logic [VW-1:0] v);
        return CW'($signed({1'b0, v}));
    endfunction

    // tone weights
    logic signed [CW-1:0] two_x;
    logic [VW-1:0]        sw_c, hw_c, mw_c;

    assign two_x = CW'($signed({1'b0, x_in})) <<< 1;
    assign sw_c  = clamp1(ONE_C - two_x);
    assign hw_c  = clamp1(two_x - ONE_C);
    assign mw_c  = ONE_V - sw_c - hw_c;

    logic [cgp_pkg::PIX_W-1:0] x1_reg, x2_reg;
    logic [VW-1:0]             sw1_reg, mw1_reg, hw1_reg;
    logic signed [PW1-1:0]     ps2_reg, pm2_reg, ph2_reg;
    logic [VW-1:0]             v3_reg, v4_reg, v5_reg, v6_reg, v8_reg, v9_reg, v10_reg;
    logic [VW-1:0]             v11_reg, v12_reg, v13_reg, v14_reg, v15_reg;
    logic [VW-1:0]             v16_reg, v17_reg, v18_reg;
    logic signed [PW1-1:0]     p5_reg, p11_reg, p14_reg, p17_reg;
    logic signed [TW-1:0]      t6_reg;
    logic signed [PW7-1:0]     p7_reg;
    logic [2*VW-1:0]           sq9_reg;
    logic signed [VW:0]        d10_reg, d13_reg, d16_reg;
    logic [cgp_pkg::OUT_W-1:0] pix_reg;

    logic signed [CW-1:0] tone_sum;
    logic [VW-1:0]        om8;

    assign tone_sum = CW'(ps2_reg) + CW'(pm2_reg) + CW'(ph2_reg);
    assign om8      = ONE_V - v8_reg;

    // dividers
    logic [VW-1:0] den1, den2, om15, vd1, vd2, t13, t16;
    logic [NW-1:0] num1, num2, q1, q2;

    assign den1 = ((ONE_V - v12_reg) < MIN_V) ? MIN_V : (ONE_V - v12_reg);
    assign num1 = NW'({v12_reg, {F{1'b0}}}) + NW'(den1 >> 1);
    assign om15 = ONE_V - v15_reg;
    assign den2 = (v15_reg < MIN_V) ? MIN_V : v15_reg;
    assign num2 = NW'({om15, {F{1'b0}}}) + NW'(den2 >> 1);

    cgp_div #(.NW(NW), .DW(VW), .TG(VW)) u_div_dodge (
        .clk     (clk),
        .en      (en),
        .num_in  (num1),
        .den_in  (den1),
        .tag_in  (v12_reg),
        .quo_out (q1),
        .tag_out (vd1)
    );

    cgp_div #(.NW(NW), .DW(VW), .TG(VW)) u_div_burn (
        .clk     (clk),
        .en      (en),
        .num_in  (num2),
        .den_in  (den2),
        .tag_in  (v15_reg),
        .quo_out (q2),
        .tag_out (vd2)
    );

    assign t13 = (q1 > NW'(ONE_V)) ? ONE_V : q1[VW-1:0];
    assign t16 = (q2 > NW'(ONE_V)) ? '0 : (ONE_V - q2[VW-1:0]);

    // v*255 + ONE/2
    logic [VW+7:0] scaled;
    assign scaled = {v18_reg, 8'd0} - (VW+8)'(v18_reg) + (VW+8)'(ONE_V >> 1);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_reg  <= x_in;
            sw1_reg <= sw_c;
            mw1_reg <= mw_c;
            hw1_reg <= hw_c;

            x2_reg  <= x1_reg;
            ps2_reg <= cfg.shadow * $signed({1'b0, sw1_reg});
            pm2_reg <= cfg.midtone * $signed({1'b0, mw1_reg});
            ph2_reg <= cfg.highlight * $signed({1'b0, hw1_reg});

            v3_reg  <= clamp1(CW'($signed({1'b0, x2_reg})) + rnd(tone_sum, F));
            v4_reg  <= clamp1(ext(v3_reg) - CW'(cfg.black));

            // multiply blend
            p5_reg  <= cfg.mult * $signed({1'b0, v4_reg} - {1'b0, ONE_V});
            v5_reg  <= v4_reg;
            t6_reg  <= TW'(ONE_C * ONE_C + CW'(p5_reg));
            v6_reg  <= v5_reg;
            p7_reg  <= $signed({1'b0, v6_reg}) * t6_reg;
            v8_reg  <= clamp1(rnd(CW'(p7_reg), 2 * F));

            // screen blend
            sq9_reg <= om8 * om8;
            v9_reg  <= v8_reg;
            d10_reg <= (VW+1)'(ONE_C - rnd(CW'(sq9_reg), F) - ext(v9_reg));
            v10_reg <= v9_reg;
            p11_reg <= d10_reg * cfg.screen;
            v11_reg <= v10_reg;
            v12_reg <= clamp1(ext(v11_reg) + rnd(CW'(p11_reg), F));

            // color dodge
            d13_reg <= (VW+1)'(ext(t13) - ext(vd1));
            v13_reg <= vd1;
            p14_reg <= d13_reg * cfg.dodge;
            v14_reg <= v13_reg;
            v15_reg <= clamp1(ext(v14_reg) + rnd(CW'(p14_reg), F));

            // color burn
            d16_reg <= (VW+1)'(ext(t16) - ext(vd2));
            v16_reg <= vd2;
            p17_reg <= d16_reg * cfg.burn;
            v17_reg <= v16_reg;
            v18_reg <= clamp1(ext(v17_reg) + rnd(CW'(p17_reg), F));

            pix_reg <= scaled[F+7:F];
        end
    end

    assign pix_out = pix_reg;

endmodule

FILE: sv/color_grading_pixel.sv
// Top level of the color grading pixel block: config registers, three channel lanes, output stage.
// From input request to result a pixel passes the lane pipeline, then the output register;
// each lane has 19 arithmetic stages plus two dividers of 2*F+1 one-bit stages.
// Throughput: one pixel per cycle; the pipeline stalls only while a finished
// result waits in the output register and another has reached the lane ends.
// Reset (rst_n low, asynchronous) clears all config registers and valid flags.
module color_grading_pixel #(
    parameter int FRAC_BITS = cgp_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [cgp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cgp_pkg::REG_W-1:0]     cfg_data,

    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [cgp_pkg::PIX_W-1:0]     red_in,
    input  logic [cgp_pkg::PIX_W-1:0]     green_in,
    input  logic [cgp_pkg::PIX_W-1:0]     blue_in,

    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [cgp_pkg::OUT_W-1:0]     red_out,
    output logic [cgp_pkg::OUT_W-1:0]     green_out,
    output logic [cgp_pkg::OUT_W-1:0]     blue_out
);

    localparam int LAT = cgp_pkg::lane_latency(FRAC_BITS);
    localparam int LW  = cgp_pkg::LANE_W;

    // ------------------------------------------------------------------
    // Configuration registers; writes are always taken, unknown indexes dropped
    // ------------------------------------------------------------------
    logic [cgp_pkg::REG_W-1:0] shadow_reg, midtone_reg, highlight_reg, black_reg;
    logic [cgp_pkg::REG_W-1:0] multiply_reg, screen_reg, dodge_reg, burn_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shadow_reg    <= '0;
            midtone_reg   <= '0;
            highlight_reg <= '0;
            black_reg     <= '0;
            multiply_reg  <= '0;
            screen_reg    <= '0;
            dodge_reg     <= '0;
            burn_reg      <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                cgp_pkg::REG_SHADOW:    shadow_reg    <= cfg_data;
                cgp_pkg::REG_MIDTONE:   midtone_reg   <= cfg_data;
                cgp_pkg::REG_HIGHLIGHT: highlight_reg <= cfg_data;
                cgp_pkg::REG_BLACK:     black_reg     <= cfg_data;
                cgp_pkg::REG_MULTIPLY:  multiply_reg  <= cfg_data;
                cgp_pkg::REG_SCREEN:    screen_reg    <= cfg_data;
                cgp_pkg::REG_DODGE:     dodge_reg     <= cfg_data;
                cgp_pkg::REG_BURN:      burn_reg      <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control: global enable, held only when the output register
    // is full, not being drained, and another result is at the lane ends
    // ------------------------------------------------------------------
    logic           vld_reg [LAT];
    logic           out_valid_reg;
    logic           stall, en, out_load;

    assign stall    = vld_reg[LAT-1] && out_valid_reg && !out_ready;
    assign en       = !stall;
    assign in_ready = en;
    assign out_load = vld_reg[LAT-1] && en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < LAT; k++)
                vld_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int k = 1; k < LAT; k++)
                vld_reg[k] <= vld_reg[k-1];
        end
    end

    // ------------------------------------------------------------------
    // Three channel lanes; register lane c sits in bits 16c+15..16c
    // ------------------------------------------------------------------
    logic [cgp_pkg::PIX_W-1:0] lane_x   [cgp_pkg::NUM_CHAN];
    logic [cgp_pkg::OUT_W-1:0] lane_pix [cgp_pkg::NUM_CHAN];
    cgp_pkg::chan_cfg_t        lane_cfg [cgp_pkg::NUM_CHAN];

    assign lane_x[0] = red_in;
    assign lane_x[1] = green_in;
    assign lane_x[2] = blue_in;

    for (genvar c = 0; c < cgp_pkg::NUM_CHAN; c++) begin : g_lane
        assign lane_cfg[c].shadow    = shadow_reg[LW*c +: LW];
        assign lane_cfg[c].midtone   = midtone_reg[LW*c +: LW];
        assign lane_cfg[c].highlight = highlight_reg[LW*c +: LW];
        assign lane_cfg[c].black     = black_reg[LW*c +: LW];
        assign lane_cfg[c].mult      = multiply_reg[LW*c +: LW];
        assign lane_cfg[c].screen    = screen_reg[LW*c +: LW];
        assign lane_cfg[c].dodge     = dodge_reg[LW*c +: LW];
        assign lane_cfg[c].burn      = burn_reg[LW*c +: LW];

        cgp_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
            .clk     (clk),
            .en      (en),
            .x_in    (lane_x[c]),
            .cfg     (lane_cfg[c]),
            .pix_out (lane_pix[c])
        );
    end

    // ------------------------------------------------------------------
    // Merge stage: the three lane results join in one output register
    // ------------------------------------------------------------------
    logic [cgp_pkg::OUT_W-1:0] red_reg, green_reg, blue_reg;
    logic                      out_valid_next;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            red_reg   <= lane_pix[0];
            green_reg <= lane_pix[1];
            blue_reg  <= lane_pix[2];
        end
    end

    assign out_valid = out_valid_reg;
    assign red_out   = red_reg;
    assign green_out = green_reg;
    assign blue_out  = blue_reg;

endmodule

FILE: test/tb_color_grading_pixel.sv
// Testbench for color_grading_pixel: directed and random pixels checked against a local grading predictor.
module tb_color_grading_pixel;

    // PIPE_DEPTH is the block's depth from input request to result; the final drain wait is longer.
    localparam int PIPE_DEPTH  = cgp_pkg::lane_latency(cgp_pkg::FRAC_BITS_DEF) + 1;
    localparam int CYCLE_LIMIT = 400000;
    localparam int NUM_REGS    = 8;
    localparam int FB          = cgp_pkg::FRAC_BITS_DEF;
    localparam int OUT_W       = cgp_pkg::OUT_W;
    localparam int PIX_W       = cgp_pkg::PIX_W;
    localparam int REG_W       = cgp_pkg::REG_W;
    localparam int LANE_W      = cgp_pkg::LANE_W;
    localparam int CFG_IDX_W   = cgp_pkg::CFG_IDX_W;
    localparam longint UNITY   = 64'sd1 << FB;
    localparam longint MIN_DEN = (UNITY + 127) / 255;

    typedef struct {
        logic [OUT_W-1:0] red;
        logic [OUT_W-1:0] green;
        logic [OUT_W-1:0] blue;
    } graded_pixel_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [REG_W-1:0]     cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [PIX_W-1:0]     red_in = '0;
    logic [PIX_W-1:0]     green_in = '0;
    logic [PIX_W-1:0]     blue_in = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [OUT_W-1:0]     red_out;
    logic [OUT_W-1:0]     green_out;
    logic [OUT_W-1:0]     blue_out;

    // Local copy of the settings registers, updated as each write request is taken.
    logic [REG_W-1:0] grade_regs [NUM_REGS];

    graded_pixel_t graded_q[$];
    int  error_count;
    int  pixels_sent;
    int  pixels_checked;
    int  cfg_writes;
    longint cycle_count;

    // Idle controls: sender gaps, receiver stall bursts, and a one-shot long hold.
    bit  tx_gaps_on;
    bit  rx_stalls_on;
    int  rx_gap_left;
    int  hold_request;
    int  hold_left;

    color_grading_pixel u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .red_in    (red_in),
        .green_in  (green_in),
        .blue_in   (blue_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .red_out   (red_out),
        .green_out (green_out),
        .blue_out  (blue_out)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Grading predictor
    // ------------------------------------------------------------------

    function automatic longint clamp_unit(input longint v);
        if (v < 0)
            return 0;
        if (v > UNITY)
            return UNITY;
        return v;
    endfunction

    // Round x / 2^s to nearest, ties toward +inf (arithmetic shift is a floor).
    function automatic longint round_shift(input longint x, input int s);
        longint y;
        y = x + (64'sd1 <<< (s - 1));
        return y >>> s;
    endfunction

    // Signed Q3.12 setting of one channel out of a packed register.
    function automatic longint reg_lane(input cgp_pkg::reg_idx_t r, input int c);
        logic signed [LANE_W-1:0] l;
        l = grade_regs[r][LANE_W*c +: LANE_W];
        return longint'(l);
    endfunction

    function automatic logic [OUT_W-1:0] grade_channel(input logic [PIX_W-1:0] xin,
                                                       input int c);
        longint x, sw, hw, mw, v, t, den;
        x  = longint'(xin);
        sw = clamp_unit(UNITY - 2 * x);
        hw = clamp_unit(2 * x - UNITY);
        mw = UNITY - sw - hw;

        // three-zone tone curve
        t = reg_lane(cgp_pkg::REG_SHADOW, c) * sw + reg_lane(cgp_pkg::REG_MIDTONE, c) * mw
            + reg_lane(cgp_pkg::REG_HIGHLIGHT, c) * hw;
        v = clamp_unit(x + round_shift(t, FB));

        v = clamp_unit(v - reg_lane(cgp_pkg::REG_BLACK, c));

        // multiply
        t = UNITY * UNITY + reg_lane(cgp_pkg::REG_MULTIPLY, c) * (v - UNITY);
        v = clamp_unit(round_shift(v * t, 2 * FB));

        // screen
        t = UNITY - round_shift((UNITY - v) * (UNITY - v), FB);
        v = clamp_unit(v + round_shift((t - v) * reg_lane(cgp_pkg::REG_SCREEN, c), FB));

        // dodge, divisor floored at 1/255
        den = (UNITY - v < MIN_DEN) ? MIN_DEN : UNITY - v;
        t = clamp_unit((v * UNITY + den / 2) / den);
        v = clamp_unit(v + round_shift((t - v) * reg_lane(cgp_pkg::REG_DODGE, c), FB));

        // burn
        den = (v < MIN_DEN) ? MIN_DEN : v;
        t = clamp_unit(UNITY - ((UNITY - v) * UNITY + den / 2) / den);
        v = clamp_unit(v + round_shift((t - v) * reg_lane(cgp_pkg::REG_BURN, c), FB));

        return OUT_W'((v * 255 + UNITY / 2) >>> FB);
    endfunction

    // ------------------------------------------------------------------
    // Result checker: samples at the falling edge, request taken at the next rise
    // ------------------------------------------------------------------

    always @(negedge clk)
    begin
        graded_pixel_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (graded_q.size() == 0)
            begin
                $error("result with no pixel outstanding: %0d %0d %0d",
                       red_out, green_out, blue_out);
                error_count++;
            end
            else
            begin
                want = graded_q.pop_front();
                pixels_checked++;
                if (red_out !== want.red)
                begin
                    $error("red_out expected %0d actual %0d", want.red, red_out);
                    error_count++;
                end
                if (green_out !== want.green)
                begin
                    $error("green_out expected %0d actual %0d", want.green, green_out);
                    error_count++;
                end
                if (blue_out !== want.blue)
                begin
                    $error("blue_out expected %0d actual %0d", want.blue, blue_out);
                    error_count++;
                end
            end
        end
    end

    // Receiver: random stall bursts, plus a long hold counted here when asked for.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_request > 0)
        begin
            out_ready    <= 1'b0;
            hold_left    <= hold_request - 1;
            hold_request <= 0;
        end
        else if (rx_gap_left > 0)
        begin
            out_ready   <= 1'b0;
            rx_gap_left <= rx_gap_left - 1;
        end
        else if (rx_stalls_on && $urandom_range(0, 7) == 0)
        begin
            out_ready   <= 1'b0;
            rx_gap_left <= $urandom_range(0, 13);
        end
        else
            out_ready <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Shared drivers; each is entered just after a rising edge
    // ------------------------------------------------------------------

    task automatic send_pixel(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                              input logic [PIX_W-1:0] b);
        graded_pixel_t want;
        in_valid <= 1'b1;
        red_in   <= r;
        green_in <= g;
        blue_in  <= b;
        do @(negedge clk); while (!in_ready);
        @(posedge clk);
        want.red   = grade_channel(r, 0);
        want.green = grade_channel(g, 1);
        want.blue  = grade_channel(b, 2);
        graded_q.push_back(want);
        pixels_sent++;
        // occasional random sender gap, in_valid held low
        if (tx_gaps_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
    endtask

    // Leaves cfg_valid high; the caller lowers it once its writes are done.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(negedge clk); while (!cfg_ready);
        @(posedge clk);
        if (idx < NUM_REGS)
            grade_regs[idx] = value;
        cfg_writes++;
    endtask

    task automatic drain_results();
        in_valid  <= 1'b0;
        cfg_valid <= 1'b0;
        while (graded_q.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [PIX_W-1:0] rand_channel();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            return '0;
        if (pick == 1)
            return PIX_W'(UNITY);
        if (pick < 4)
            return PIX_W'($urandom_range(UNITY + 1, 8191));
        return PIX_W'($urandom_range(0, UNITY));
    endfunction

    // One lane of a register: mostly moderate strengths, some full-range and extremes.
    function automatic logic [LANE_W-1:0] rand_lane();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return 16'h7FFF;
            2: return 16'h8000;
            3: return LANE_W'($urandom);
            default: return LANE_W'($urandom_range(0, 4096) - 2048);
        endcase
    endfunction

    function automatic logic [REG_W-1:0] rand_reg();
        return {rand_lane(), rand_lane(), rand_lane()};
    endfunction

    task automatic send_random(input int count);
        repeat (count)
            send_pixel(rand_channel(), rand_channel(), rand_channel());
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset settings are all zero, so the block only clamps each 13-bit input to unity and rounds it to 8 bits.
    task automatic test_reset_passthrough();
        send_pixel(13'd0, 13'd4096, 13'd2048);
        send_pixel(13'd1, 13'd4095, 13'd4097);
        send_pixel(13'd8191, 13'h0AAA, 13'h1555);
        send_pixel(13'd16, 13'd8, 13'd2047);
        drain_results();
    endtask

    // Every register at its positive and negative extremes, and a write to an unused index.
    task automatic test_extreme_settings();
        for (int r = 0; r < NUM_REGS; r++)
        begin
            write_reg(CFG_IDX_W'(r), 48'h7FFF_8000_0800);
            cfg_valid <= 1'b0;
            send_pixel(13'd0, 13'd1024, 13'd3072);
            drain_results();
            // the next write follows directly, so valid stays up
            write_reg(CFG_IDX_W'(r), '0);
        end
        // black level and full blend stack at their most negative, inputs across the whole range
        for (int r = cgp_pkg::REG_BLACK; r < NUM_REGS; r++)
            write_reg(CFG_IDX_W'(r), {3{16'h8000}});
        write_reg(4'hF, '1);
        cfg_valid <= 1'b0;
        send_pixel(13'd2048, 13'd4096, 13'd8191);
        send_pixel(13'd0, 13'd17, 13'd4079);
        drain_results();
    endtask

    // Random phases: fresh settings, then random pixels with idling on both sides.
    task automatic test_random_phases(input int phases, input int per_phase);
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
        for (int p = 0; p < phases; p++)
        begin
            for (int r = 0; r < NUM_REGS; r++)
                write_reg(CFG_IDX_W'(r), ($urandom_range(0, 5) == 0) ? '0 : rand_reg());
            if ($urandom_range(0, 2) == 0)
                write_reg(CFG_IDX_W'($urandom_range(NUM_REGS, 15)),
                          REG_W'({$urandom, $urandom}));
            cfg_valid <= 1'b0;
            send_random(per_phase);
            drain_results();
        end
    endtask

    // Receiver holds off long enough for the pipe to fill and stall the input.
    task automatic test_output_backpressure();
        hold_request <= 4 * PIPE_DEPTH;
        tx_gaps_on = 1'b0;
        send_random(3 * PIPE_DEPTH);
        drain_results();
    endtask

    // Sender stops until all graded pixels are back, then resumes.
    task automatic test_sender_pause();
        tx_gaps_on = 1'b1;
        send_random(40);
        drain_results();
        send_random(40);
        drain_results();
    endtask

    // Back-to-back stream with no idling anywhere.
    task automatic test_full_rate(input int count);
        tx_gaps_on   = 1'b0;
        rx_stalls_on = 1'b0;
        write_reg(cgp_pkg::REG_SHADOW, rand_reg());
        write_reg(cgp_pkg::REG_SCREEN, rand_reg());
        write_reg(cgp_pkg::REG_BURN, rand_reg());
        cfg_valid <= 1'b0;
        send_random(count);
        drain_results();
    endtask

    initial
    begin
        for (int r = 0; r < NUM_REGS; r++)
            grade_regs[r] = '0;
        error_count = 0;
        pixels_sent = 0;
        pixels_checked = 0;
        cfg_writes = 0;
        cycle_count = 0;
        tx_gaps_on = 1'b0;
        rx_stalls_on = 1'b0;
        rx_gap_left = 0;
        hold_request = 0;
        hold_left = 0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_passthrough();
        test_extreme_settings();
        test_random_phases(8, 60);
        test_output_backpressure();
        test_sender_pause();
        test_full_rate(150);

        // let any stray result show up before the verdict
        repeat (2 * PIPE_DEPTH) @(posedge clk);
        if (graded_q.size() != 0)
        begin
            $error("%0d graded pixels never came out", graded_q.size());
            error_count++;
        end

        $display("covered %0d pixels, %0d checked, %0d settings writes",
                 pixels_sent, pixels_checked, cfg_writes);
        $display("includes out-of-range inputs, unused register index, long output hold");
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
